FILE: design/lm3_pkg.sv
// Shared constants and types for the 3x3 local maximum detector.
`default_nettype none
package lm3_pkg;

  localparam int DEF_MAX_COLS   = 1024;
  localparam int DEF_PIXEL_BITS = 16;

  localparam int ROW_W       = 16;
  localparam int FCOL_W      = 11;
  localparam int COUNT_W     = 26;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COLS = 2'd1;

  // Result queue between the frame tracker and the output port.
  localparam int RES_DEPTH = 2;
  localparam int RES_CNT_W = 2;
  localparam int PEND_W    = 3;

  typedef struct packed {
    logic last_col;
    logic last_row;
    logic frame_end;
  } item_flags_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic lower;
    logic frame_end;
  } cand_ctl_t;

  typedef struct packed {
    logic                 done_valid;
    logic [RES_CNT_W-1:0] res_cnt;
  } trk_status_t;

endpackage
`default_nettype wire

FILE: design/lm3_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module lm3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: design/lm3_window.sv
// Line store, 3x3 window and peak decisions for one pixel per transaction.
`default_nettype none
module lm3_window #(
  parameter int MAX_COLS   = lm3_pkg::DEF_MAX_COLS,
  parameter int PIXEL_BITS = lm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_take,
  input  logic signed [PIXEL_BITS-1:0]        in_pixel,
  input  logic [lm3_pkg::ROW_W-1:0]           in_row,
  input  logic [$clog2(MAX_COLS)-1:0]         in_col,
  input  lm3_pkg::item_flags_t                in_flags,
  output logic                                s1_end,
  output lm3_pkg::cand_ctl_t                  cand,
  output logic signed [PIXEL_BITS-1:0]        cand_value,
  output logic [lm3_pkg::ROW_W-1:0]           cand_row,
  output logic [lm3_pkg::FCOL_W-1:0]          cand_col
);
  import lm3_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int WORD_W = 2 * PIXEL_BITS;

  typedef logic signed [PIXEL_BITS-1:0] pix_t;

  // Stage one: the item whose line store read is returning.
  logic                s1_valid;
  pix_t                s1_pixel;
  logic [ROW_W-1:0]    s1_row;
  logic [COL_W-1:0]    s1_col;
  item_flags_t         s1_flags;

  logic                fwd_hit;
  logic [WORD_W-1:0]   fwd_data;
  logic [WORD_W-1:0]   ram_rdata;
  logic [WORD_W-1:0]   rd_word;
  logic [WORD_W-1:0]   wr_word;

  // Column vectors: index 0 is two rows up, 1 is one row up, 2 is the current row.
  pix_t w1 [3];
  pix_t w2 [3];
  pix_t cur [3];
  pix_t l1 [3];
  pix_t l2 [3];

  logic r_ge1, r_ge2, c_ge1, c_ge2;
  logic up_a, up_b, lo_a, lo_b;

  pix_t                sel_value;
  logic [ROW_W-1:0]    sel_row;
  logic [FCOL_W-1:0]   sel_col;
  logic                sel_lower;
  logic [FCOL_W-1:0]   col_here;
  logic [FCOL_W-1:0]   col_right;

  function automatic logic is_peak(input pix_t ctr, input pix_t nb [8]);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < 8; i++) begin
      if (!(ctr > nb[i])) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  lm3_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_COLS)
  ) u_line (
    .clk  (clk),
    .we   (s1_valid),
    .waddr(s1_col),
    .wdata(wr_word),
    .raddr(in_col),
    .rdata(ram_rdata)
  );

  always_comb begin
    r_ge1 = (s1_row != '0);
    r_ge2 = (s1_row[ROW_W-1:1] != '0);
    c_ge1 = (s1_col != '0);
    c_ge2 = (s1_col[COL_W-1:1] != '0);

    rd_word = fwd_hit ? fwd_data : ram_rdata;
    cur[0]  = r_ge2 ? pix_t'(rd_word[PIXEL_BITS-1:0]) : pix_t'(0);
    cur[1]  = r_ge1 ? pix_t'(rd_word[WORD_W-1:PIXEL_BITS]) : pix_t'(0);
    cur[2]  = s1_pixel;
    wr_word = {s1_pixel, cur[1]};

    for (int i = 0; i < 3; i++) begin
      l1[i] = c_ge1 ? w1[i] : pix_t'(0);
      l2[i] = c_ge2 ? w2[i] : pix_t'(0);
    end

    // Centres one row up, then centres in the last row, whose lower row is outside.
    up_a = r_ge1 && c_ge1 &&
           is_peak(l1[1], '{l2[0], l2[1], l2[2], l1[0], l1[2], cur[0], cur[1], cur[2]});
    up_b = r_ge1 && s1_flags.last_col &&
           is_peak(cur[1], '{l1[0], l1[1], l1[2], cur[0], cur[2], '0, '0, '0});
    lo_a = s1_flags.last_row && c_ge1 &&
           is_peak(l1[2], '{l2[1], l2[2], l1[1], cur[1], cur[2], '0, '0, '0});
    lo_b = s1_flags.last_row && s1_flags.last_col &&
           is_peak(cur[2], '{l1[1], l1[2], cur[1], '0, '0, '0, '0, '0});

    col_here  = FCOL_W'(32'(s1_col));
    col_right = FCOL_W'(32'(s1_col) + 32'd1);

    // The four centres are mutually adjacent, so at most one of them is a peak.
    sel_value = cur[2];
    sel_row   = s1_row + ROW_W'(1);
    sel_col   = col_right;
    sel_lower = 1'b1;
    if (up_a) begin
      sel_value = l1[1];
      sel_row   = s1_row;
      sel_col   = col_here;
      sel_lower = 1'b0;
    end else if (up_b) begin
      sel_value = cur[1];
      sel_row   = s1_row;
      sel_col   = col_right;
      sel_lower = 1'b0;
    end else if (lo_a) begin
      sel_value = l1[2];
      sel_row   = s1_row + ROW_W'(1);
      sel_col   = col_here;
      sel_lower = 1'b1;
    end
  end

  assign s1_end = s1_valid && s1_flags.frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
      cand     <= '0;
    end else begin
      s1_valid <= in_take;
      // A read issued while the same column is being written returns stale data.
      fwd_hit  <= s1_valid && (s1_col == in_col);
      cand.valid     <= s1_valid;
      cand.hit       <= s1_valid && (up_a || up_b || lo_a || lo_b);
      cand.lower     <= sel_lower;
      cand.frame_end <= s1_valid && s1_flags.frame_end;
    end
    fwd_data <= wr_word;
    if (in_take) begin
      s1_pixel <= in_pixel;
      s1_row   <= in_row;
      s1_col   <= in_col;
      s1_flags <= in_flags;
    end
    if (s1_valid) begin
      for (int i = 0; i < 3; i++) begin
        w1[i] <= cur[i];
        w2[i] <= w1[i];
      end
      cand_value <= sel_value;
      cand_row   <= sel_row;
      cand_col   <= sel_col;
    end
  end

endmodule
`default_nettype wire

FILE: design/lm3_track.sv
// Peak count, strongest peak tracking and the end-of-frame result queue.
`default_nettype none
module lm3_track #(
  parameter int PIXEL_BITS = lm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            clear,
  input  lm3_pkg::cand_ctl_t              cand,
  input  logic signed [PIXEL_BITS-1:0]    cand_value,
  input  logic [lm3_pkg::ROW_W-1:0]       cand_row,
  input  logic [lm3_pkg::FCOL_W-1:0]      cand_col,
  output lm3_pkg::trk_status_t            status,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lm3_pkg::COUNT_W-1:0]     peak_count,
  output logic                            peak_found,
  output logic [lm3_pkg::ROW_W-1:0]       peak_row,
  output logic [lm3_pkg::FCOL_W-1:0]      peak_col,
  output logic [PIXEL_BITS-2:0]           peak_value
);
  import lm3_pkg::*;

  localparam int PTR_W = $clog2(RES_DEPTH);

  typedef logic signed [PIXEL_BITS-1:0] pix_t;

  // Running frame state: rows above the last row, and the last row on its own.
  logic [COUNT_W-1:0] run_count, run_count_next;
  pix_t               up_val, up_val_next, lo_val, lo_val_next;
  logic [ROW_W-1:0]   up_row, up_row_next, lo_row, lo_row_next;
  logic [FCOL_W-1:0]  up_col, up_col_next, lo_col, lo_col_next;

  // Snapshot of a finished frame.
  logic               done_valid;
  logic [COUNT_W-1:0] done_count;
  pix_t               done_up_val, done_lo_val;
  logic [ROW_W-1:0]   done_up_row, done_lo_row;
  logic [FCOL_W-1:0]  done_up_col, done_lo_col;

  pix_t               fin_val;
  logic [ROW_W-1:0]   fin_row;
  logic [FCOL_W-1:0]  fin_col;

  logic [COUNT_W-1:0]    res_count [RES_DEPTH];
  logic                  res_found [RES_DEPTH];
  logic [ROW_W-1:0]      res_row   [RES_DEPTH];
  logic [FCOL_W-1:0]     res_col   [RES_DEPTH];
  logic [PIXEL_BITS-2:0] res_value [RES_DEPTH];
  logic [PTR_W-1:0]      wr_ptr, rd_ptr;
  logic [RES_CNT_W-1:0]  res_cnt;
  logic                  push, pop;

  always_comb begin
    run_count_next = run_count;
    up_val_next    = up_val;
    up_row_next    = up_row;
    up_col_next    = up_col;
    lo_val_next    = lo_val;
    lo_row_next    = lo_row;
    lo_col_next    = lo_col;
    if (cand.hit) begin
      if (run_count != COUNT_MAX) begin
        run_count_next = run_count + COUNT_W'(1);
      end
      // Strictly greater keeps the earlier peak on ties.
      if (cand.lower) begin
        if (cand_value > lo_val) begin
          lo_val_next = cand_value;
          lo_row_next = cand_row;
          lo_col_next = cand_col;
        end
      end else if (cand_value > up_val) begin
        up_val_next = cand_value;
        up_row_next = cand_row;
        up_col_next = cand_col;
      end
    end

    if (done_lo_val > done_up_val) begin
      fin_val = done_lo_val;
      fin_row = done_lo_row;
      fin_col = done_lo_col;
    end else begin
      fin_val = done_up_val;
      fin_row = done_up_row;
      fin_col = done_up_col;
    end
  end

  assign push = done_valid;
  assign pop  = out_valid && !out_stall;

  assign out_valid  = (res_cnt != '0);
  assign peak_count = res_count[rd_ptr];
  assign peak_found = res_found[rd_ptr];
  assign peak_row   = res_row[rd_ptr];
  assign peak_col   = res_col[rd_ptr];
  assign peak_value = res_value[rd_ptr];

  assign status.done_valid = done_valid;
  assign status.res_cnt    = res_cnt;

  always_ff @(posedge clk) begin
    if (rst || clear || (cand.valid && cand.frame_end)) begin
      run_count <= '0;
      up_val    <= '0;
      up_row    <= '0;
      up_col    <= '0;
      lo_val    <= '0;
      lo_row    <= '0;
      lo_col    <= '0;
    end else if (cand.valid) begin
      run_count <= run_count_next;
      up_val    <= up_val_next;
      up_row    <= up_row_next;
      up_col    <= up_col_next;
      lo_val    <= lo_val_next;
      lo_row    <= lo_row_next;
      lo_col    <= lo_col_next;
    end

    if (rst) begin
      done_valid <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      res_cnt    <= '0;
    end else begin
      done_valid <= cand.valid && cand.frame_end;
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        res_cnt <= res_cnt + RES_CNT_W'(1);
      end else if (pop && !push) begin
        res_cnt <= res_cnt - RES_CNT_W'(1);
      end
    end

    if (cand.valid && cand.frame_end) begin
      done_count  <= run_count_next;
      done_up_val <= up_val_next;
      done_up_row <= up_row_next;
      done_up_col <= up_col_next;
      done_lo_val <= lo_val_next;
      done_lo_row <= lo_row_next;
      done_lo_col <= lo_col_next;
    end

    if (push) begin
      res_count[wr_ptr] <= done_count;
      res_found[wr_ptr] <= (fin_val != '0);
      res_row[wr_ptr]   <= fin_row;
      res_col[wr_ptr]   <= fin_col;
      res_value[wr_ptr] <= fin_val[PIXEL_BITS-2:0];
    end
  end

endmodule
`default_nettype wire

FILE: design/local_maximum_3x3_detector.sv
// Top level of the 3x3 strict local maximum detector with frame counters and config.
//
// Pixels enter in raster order on in_valid/pixel, one transaction per pixel; the
// block raises in_stall to hold one back. A pixel is a peak when it is strictly
// greater than its eight neighbors, with neighbors outside the frame taken as zero.
// After the last pixel of a frame one result transaction appears on out_valid with
// the saturating peak count and the first strongest positive peak (1-based row and
// column, value, found flag); out_stall holds it. frame_rows (index 0) and
// frame_cols (index 1) are written through cfg_valid/cfg_index/cfg_data; the user
// must write them only while idle, which the block does not enforce; cfg_ready is
// always high, and any write restarts the frame. Throughput is one pixel per cycle
// while in_stall is low, set by the line store: one dual-port RAM of MAX_COLS words
// holding the two previous rows, read and written once per pixel. Up to two results
// may wait at the output; in_stall rises only on a frame's last pixel when two
// results are already waiting or in flight. Reset sets both frame sizes to one and
// clears position, count and peak state; the line store needs no clearing.
`default_nettype none
module local_maximum_3x3_detector #(
  parameter int MAX_COLS   = lm3_pkg::DEF_MAX_COLS,
  parameter int PIXEL_BITS = lm3_pkg::DEF_PIXEL_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [PIXEL_BITS-1:0]      pixel,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [lm3_pkg::COUNT_W-1:0]       peak_count,
  output logic                              peak_found,
  output logic [lm3_pkg::ROW_W-1:0]         peak_row,
  output logic [lm3_pkg::FCOL_W-1:0]        peak_col,
  output logic [PIXEL_BITS-2:0]             peak_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lm3_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lm3_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import lm3_pkg::*;

  localparam int COL_W = $clog2(MAX_COLS);

  logic [ROW_W-1:0]  frame_rows;
  logic [FCOL_W-1:0] frame_cols;
  logic [ROW_W-1:0]  row_pos;
  logic [COL_W-1:0]  col_pos;

  logic [31:0]       ncols_eff;
  logic [COL_W-1:0]  last_col_idx;
  logic [ROW_W-1:0]  last_row_idx;
  item_flags_t       in_flags;

  logic              cfg_we;
  logic              in_take;
  logic [PEND_W-1:0] pending;

  logic                   s1_end;
  cand_ctl_t              cand;
  logic signed [PIXEL_BITS-1:0] cand_value;
  logic [ROW_W-1:0]       cand_row;
  logic [FCOL_W-1:0]      cand_col;
  trk_status_t            trk_status;

  always_comb begin
    if (frame_cols == '0) begin
      ncols_eff = 32'd1;
    end else if (32'(frame_cols) > 32'(MAX_COLS)) begin
      ncols_eff = 32'(MAX_COLS);
    end else begin
      ncols_eff = 32'(frame_cols);
    end
    last_col_idx = COL_W'(ncols_eff - 32'd1);
    last_row_idx = (frame_rows == '0) ? '0 : frame_rows - ROW_W'(1);

    in_flags.last_col  = (col_pos == last_col_idx);
    in_flags.last_row  = (row_pos == last_row_idx);
    in_flags.frame_end = in_flags.last_col && in_flags.last_row;

    // Results in flight to or waiting in the output queue, counted from every stage.
    pending = PEND_W'(s1_end) + PEND_W'(cand.valid && cand.frame_end) +
              PEND_W'(trk_status.done_valid) + PEND_W'(trk_status.res_cnt);
  end

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = in_flags.frame_end && (pending >= PEND_W'(RES_DEPTH));
  assign in_take   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= ROW_W'(1);
      frame_cols <= FCOL_W'(1);
      row_pos    <= '0;
      col_pos    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_ROWS: frame_rows <= cfg_data[ROW_W-1:0];
        REG_FRAME_COLS: frame_cols <= cfg_data[FCOL_W-1:0];
        default: ;
      endcase
      row_pos <= '0;
      col_pos <= '0;
    end else if (in_take) begin
      if (in_flags.last_col) begin
        col_pos <= '0;
        row_pos <= in_flags.last_row ? '0 : row_pos + ROW_W'(1);
      end else begin
        col_pos <= col_pos + COL_W'(1);
      end
    end
  end

  lm3_window #(
    .MAX_COLS  (MAX_COLS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .in_take   (in_take),
    .in_pixel  (pixel),
    .in_row    (row_pos),
    .in_col    (col_pos),
    .in_flags  (in_flags),
    .s1_end    (s1_end),
    .cand      (cand),
    .cand_value(cand_value),
    .cand_row  (cand_row),
    .cand_col  (cand_col)
  );

  lm3_track #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_track (
    .clk       (clk),
    .rst       (rst),
    .clear     (cfg_we),
    .cand      (cand),
    .cand_value(cand_value),
    .cand_row  (cand_row),
    .cand_col  (cand_col),
    .status    (trk_status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .peak_count(peak_count),
    .peak_found(peak_found),
    .peak_row  (peak_row),
    .peak_col  (peak_col),
    .peak_value(peak_value)
  );

endmodule
`default_nettype wire
